// ----- rtl/sled_pkg.sv -----
// ----------------------------------------------------------------------------
// sled_pkg
// Types, constants and the breathe table shared by the status LED pattern
// engine.
// ----------------------------------------------------------------------------
package sled_pkg;

	localparam int CHANNELS      = 8;
	localparam int BREATHE_STEPS = 60;

	// Pattern slots that carry a stored pattern; higher channels stay dark.
	localparam int PAT_SLOTS  = 8;
	localparam int PAT_IDX_W  = 3;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CHF_W      = 3;
	localparam int DUTY_W     = 12;
	localparam int SLOW_W     = 5;
	localparam int FAST_W     = 3;
	localparam int BR_W       = 6;
	localparam int CFG_ADDR_W = 2;

	localparam logic [SLOW_W-1:0] SLOW_PERIOD = SLOW_W'(20);
	localparam logic [SLOW_W-1:0] SLOW_ON     = SLOW_W'(12);
	localparam logic [FAST_W-1:0] FAST_PERIOD = FAST_W'(5);
	localparam logic [FAST_W-1:0] FAST_ON     = FAST_W'(2);
	localparam logic [BR_W-1:0]   BR_LAST     = BR_W'(BREATHE_STEPS - 1);
	localparam logic [DUTY_W-1:0] DUTY_MAX    = DUTY_W'(4095);
	localparam logic [DUTY_W-1:0] FULL_RESET  = DUTY_W'(4095);
	localparam logic [DUTY_W-1:0] DIM_RESET   = DUTY_W'(512);

	localparam logic [CFG_ADDR_W-1:0] REG_FULL_LEVEL = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_DIM_LEVEL  = CFG_ADDR_W'(1);

	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_HEALTH = 1'b1;

	typedef enum logic [2:0] {
		PAT_OFF    = 3'd0,
		PAT_STEADY = 3'd1,
		PAT_DIM    = 3'd2,
		PAT_SLOW   = 3'd3,
		PAT_FAST   = 3'd4,
		PAT_PULSE  = 3'd5
	} pat_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} sled_state_t;

	typedef struct packed {
		logic kind;
		logic any_fault;
		logic heap_alert;
		logic storage_critical;
		logic battery_ok;
		logic node_c_seen;
		logic wifi_up;
		logic node_a_live;
		logic node_c_live;
		logic node_a_heard;
		logic node_c_heard;
		logic pump_bit;
	} sled_in_t;

	typedef struct packed {
		logic [CHF_W-1:0]  channel;
		logic [DUTY_W-1:0] duty;
		logic              full_on;
		logic              full_off;
		logic              last;
	} sled_out_t;

	typedef struct packed {
		logic [SLOW_W-1:0] slow;
		logic [FAST_W-1:0] fast;
		logic [BR_W-1:0]   breathe;
	} sled_phase_t;

	// Half-sine breathe curve; entries from step 33 upward are zero.
	function automatic logic [DUTY_W-1:0] breathe_rom(input logic [BR_W-1:0] idx);
		logic [DUTY_W-1:0] v;
		case (idx)
			6'd1:    v = 12'd142;
			6'd2:    v = 12'd284;
			6'd3:    v = 12'd424;
			6'd4:    v = 12'd561;
			6'd5:    v = 12'd693;
			6'd6:    v = 12'd819;
			6'd7:    v = 12'd938;
			6'd8:    v = 12'd1048;
			6'd9:    v = 12'd1148;
			6'd10:   v = 12'd1238;
			6'd11:   v = 12'd1317;
			6'd12:   v = 12'd1383;
			6'd13:   v = 12'd1437;
			6'd14:   v = 12'd1478;
			6'd15:   v = 12'd1505;
			6'd16:   v = 12'd1518;
			6'd17:   v = 12'd1518;
			6'd18:   v = 12'd1505;
			6'd19:   v = 12'd1478;
			6'd20:   v = 12'd1437;
			6'd21:   v = 12'd1383;
			6'd22:   v = 12'd1317;
			6'd23:   v = 12'd1238;
			6'd24:   v = 12'd1148;
			6'd25:   v = 12'd1048;
			6'd26:   v = 12'd938;
			6'd27:   v = 12'd819;
			6'd28:   v = 12'd693;
			6'd29:   v = 12'd561;
			6'd30:   v = 12'd424;
			6'd31:   v = 12'd284;
			6'd32:   v = 12'd142;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Channel field is the low three bits of the channel counter.
	function automatic logic [CHF_W-1:0] chan_field(input logic [CH_W-1:0] c);
		logic [CH_W+CHF_W-1:0] ext;
		ext = {{CHF_W{1'b0}}, c};
		return ext[CHF_W-1:0];
	endfunction

	// True for channels that own a pattern slot.
	function automatic logic chan_has_slot(input logic [CH_W-1:0] c);
		logic [CH_W+CHF_W-1:0] ext;
		ext = {{CHF_W{1'b0}}, c};
		return (ext[CH_W+CHF_W-1:PAT_IDX_W] == '0);
	endfunction

endpackage

// ----- rtl/sled_if.sv -----
// ----------------------------------------------------------------------------
// sled_if
// Valid/ready channels of the status LED pattern engine: input items,
// result items and configuration writes.
// ----------------------------------------------------------------------------
interface sled_in_if;
	import sled_pkg::*;
	logic     valid;
	logic     ready;
	sled_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sled_out_if;
	import sled_pkg::*;
	logic      valid;
	logic      ready;
	sled_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sled_cfg_if;
	import sled_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CFG_ADDR_W-1:0]   addr;
	logic [DUTY_W-1:0]       wdata;
	modport source (output valid, output addr, output wdata, input ready);
	modport sink (input valid, input addr, input wdata, output ready);
endinterface

// ----- rtl/status_led_pattern_engine.sv -----
// ----------------------------------------------------------------------------
// status_led_pattern_engine
// Status LED pattern engine: health updates set per-channel patterns, display
// ticks emit one duty result per channel.
// ----------------------------------------------------------------------------
// A health update is accepted in the idle state and produces no result. A
// display tick is accepted in the idle state and then walks the channels with
// a single shared duty unit, one channel per cycle while the result register
// is free. The input is not ready while the channel walk runs; the final
// result may still wait in the output register when the next item is taken.
// The phase counters advance as the last channel's result is loaded.
module status_led_pattern_engine (
	input  logic        clk,
	input  logic        arst_n,
	sled_in_if.sink     item,
	sled_out_if.source  result,
	sled_cfg_if.sink    cfg
);
	import sled_pkg::*;

	sled_state_t          state_q, state_d;
	logic [CH_W-1:0]      ch_q;
	logic                 out_vld_q;
	sled_out_t            out_q;
	logic [DUTY_W-1:0]    full_q, dim_q;
	logic                 accept_in, load_out, last_ch, health_wr;
	pat_t                 slot_pat, ch_pat;
	sled_phase_t          phase;
	logic [DUTY_W-1:0]    duty;
	logic                 full_on, full_off;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign accept_in  = item.valid && item.ready;
	assign health_wr  = accept_in && (item.data.kind == KIND_HEALTH);
	assign load_out   = (state_q == ST_RUN) && (!out_vld_q || result.ready);
	assign last_ch    = (ch_q == CH_W'(CHANNELS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in && item.data.kind == KIND_TICK) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (load_out && last_ch) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
		end else if (accept_in) begin
			ch_q <= '0;
		end else if (load_out) begin
			ch_q <= last_ch ? '0 : ch_q + CH_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= FULL_RESET;
			dim_q  <= DIM_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				REG_FULL_LEVEL: full_q <= cfg.wdata;
				REG_DIM_LEVEL:  dim_q  <= cfg.wdata;
				default:        ;
			endcase
		end
	end

	sled_pattern_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (health_wr),
		.flags  (item.data),
		.rd_idx (chan_field(ch_q)),
		.rd_pat (slot_pat)
	);

	assign ch_pat = chan_has_slot(ch_q) ? slot_pat : PAT_OFF;

	sled_phase_ctr u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (load_out && last_ch),
		.phase  (phase)
	);

	sled_duty_unit u_duty (
		.pat        (ch_pat),
		.phase      (phase),
		.full_level (full_q),
		.dim_level  (dim_q),
		.duty       (duty),
		.full_on    (full_on),
		.full_off   (full_off)
	);

	// Output register: a transfer frees it, a new channel result refills it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.channel  <= chan_field(ch_q);
			out_q.duty     <= duty;
			out_q.full_on  <= full_on;
			out_q.full_off <= full_off;
			out_q.last     <= last_ch;
		end
	end

	assign result.valid = out_vld_q;
	assign result.data  = out_q;

endmodule

// ----- rtl/sled_pattern_store.sv -----
// ----------------------------------------------------------------------------
// sled_pattern_store
// Maps a health update to one pattern per LED slot and holds the patterns.
// ----------------------------------------------------------------------------
module sled_pattern_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  sled_pkg::sled_in_t          flags,
	input  logic [sled_pkg::PAT_IDX_W-1:0] rd_idx,
	output sled_pkg::pat_t              rd_pat
);
	import sled_pkg::*;

	pat_t pat_q [PAT_SLOTS];
	pat_t pat_d [PAT_SLOTS];

	always_comb begin
		pat_d[0] = flags.any_fault ? PAT_FAST : PAT_PULSE;
		pat_d[1] = flags.any_fault ? PAT_STEADY : PAT_OFF;
		pat_d[2] = (flags.node_a_live || flags.node_c_live) ? PAT_STEADY :
		           ((flags.node_a_heard || flags.node_c_heard) ? PAT_SLOW : PAT_OFF);
		pat_d[3] = flags.wifi_up ? PAT_STEADY : PAT_SLOW;
		pat_d[4] = flags.node_a_live ? PAT_STEADY :
		           (flags.node_a_heard ? PAT_DIM : PAT_OFF);
		pat_d[5] = flags.node_c_live ? PAT_STEADY :
		           (flags.node_c_seen ? PAT_DIM : PAT_OFF);
		pat_d[6] = (flags.node_c_live && flags.pump_bit) ? PAT_FAST : PAT_OFF;
		pat_d[7] = (flags.heap_alert || flags.storage_critical ||
		            (flags.node_c_seen && !flags.battery_ok)) ? PAT_SLOW : PAT_OFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAT_SLOTS; i++) pat_q[i] <= PAT_OFF;
		end else if (wr_en) begin
			for (int i = 0; i < PAT_SLOTS; i++) pat_q[i] <= pat_d[i];
		end
	end

	assign rd_pat = pat_q[rd_idx];

endmodule

// ----- rtl/sled_phase_ctr.sv -----
// ----------------------------------------------------------------------------
// sled_phase_ctr
// Modular phase counters for slow blink, fast blink and the breathe table.
// ----------------------------------------------------------------------------
module sled_phase_ctr (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	output sled_pkg::sled_phase_t phase
);
	import sled_pkg::*;

	sled_phase_t phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (adv) begin
			phase_q.slow    <= (phase_q.slow == SLOW_PERIOD - SLOW_W'(1)) ? '0 :
			                   phase_q.slow + SLOW_W'(1);
			phase_q.fast    <= (phase_q.fast == FAST_PERIOD - FAST_W'(1)) ? '0 :
			                   phase_q.fast + FAST_W'(1);
			phase_q.breathe <= (phase_q.breathe == BR_LAST) ? '0 :
			                   phase_q.breathe + BR_W'(1);
		end
	end

	assign phase = phase_q;

endmodule

// ----- rtl/sled_duty_unit.sv -----
// ----------------------------------------------------------------------------
// sled_duty_unit
// Shared duty evaluator: turns one channel's pattern and the current phases
// into its PWM duty and full-on / full-off flags.
// ----------------------------------------------------------------------------
module sled_duty_unit (
	input  sled_pkg::pat_t              pat,
	input  sled_pkg::sled_phase_t       phase,
	input  logic [sled_pkg::DUTY_W-1:0] full_level,
	input  logic [sled_pkg::DUTY_W-1:0] dim_level,
	output logic [sled_pkg::DUTY_W-1:0] duty,
	output logic                        full_on,
	output logic                        full_off
);
	import sled_pkg::*;

	always_comb begin
		case (pat)
			PAT_STEADY: duty = full_level;
			PAT_DIM:    duty = dim_level;
			PAT_SLOW:   duty = (phase.slow < SLOW_ON) ? full_level : '0;
			PAT_FAST:   duty = (phase.fast < FAST_ON) ? full_level : '0;
			PAT_PULSE:  duty = breathe_rom(phase.breathe);
			default:    duty = '0;
		endcase
		full_on  = (duty == DUTY_MAX);
		full_off = (duty == '0);
	end

endmodule

// ----- sim/status_led_pattern_engine_test.sv -----
// ----------------------------------------------------------------------------
// status_led_pattern_engine_test
// Self-checking testbench for the status LED pattern engine. Health updates
// and display ticks are sent over the item channel. A local model of the
// channel patterns, phase counters and duty levels predicts the eight duty
// results of every tick. Each result is checked against the oldest prediction
// in every test; some tests let both channels idle at random or hold results off.
// ----------------------------------------------------------------------------
module status_led_pattern_engine_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sled_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int SETTLE_CYCLES = CHANNELS + 4;
	localparam int HOLD_CYCLES   = 150;
	localparam int REPORT_LIMIT  = 10;
	localparam int CURVE_LIT     = 33;
	localparam longint TIMEOUT_NS = 4_000_000;

	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = CFG_ADDR_W'(2);
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = CFG_ADDR_W'(3);

	logic clk;
	logic arst_n;

	sled_in_if  item_ch ();
	sled_out_if result_ch ();
	sled_cfg_if cfg_ch ();

	status_led_pattern_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Lit part of the breathe curve; every later step is dark.
	logic [DUTY_W-1:0] breathe_curve [0:CURVE_LIT-1] = '{
		12'd0,    12'd142,  12'd284,  12'd424,  12'd561,  12'd693,  12'd819,
		12'd938,  12'd1048, 12'd1148, 12'd1238, 12'd1317, 12'd1383, 12'd1437,
		12'd1478, 12'd1505, 12'd1518, 12'd1518, 12'd1505, 12'd1478, 12'd1437,
		12'd1383, 12'd1317, 12'd1238, 12'd1148, 12'd1048, 12'd938,  12'd819,
		12'd693,  12'd561,  12'd424,  12'd284,  12'd142
	};

	// Local copy of the engine state.
	pat_t              chan_pat [PAT_SLOTS];
	logic [SLOW_W-1:0] slow_ph;
	logic [FAST_W-1:0] fast_ph;
	logic [BR_W-1:0]   breathe_ph;
	logic [DUTY_W-1:0] full_lvl;
	logic [DUTY_W-1:0] dim_lvl;

	sled_out_t duty_queue [$];
	sled_out_t want;
	int        fail_count;
	int        send_idle_pct;
	int        recv_idle_pct;
	logic      hold_off;

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	initial begin
		#TIMEOUT_NS;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [DUTY_W-1:0] duty_for(input pat_t p);
		case (p)
			PAT_STEADY: return full_lvl;
			PAT_DIM:    return dim_lvl;
			PAT_SLOW:   return (slow_ph < SLOW_ON) ? full_lvl : '0;
			PAT_FAST:   return (fast_ph < FAST_ON) ? full_lvl : '0;
			PAT_PULSE:  return (breathe_ph < CURVE_LIT) ? breathe_curve[breathe_ph] : '0;
			default:    return '0;
		endcase
	endfunction

	function automatic void map_health(input sled_in_t h);
		chan_pat[0] = h.any_fault ? PAT_FAST : PAT_PULSE;
		chan_pat[1] = h.any_fault ? PAT_STEADY : PAT_OFF;
		chan_pat[2] = (h.node_a_live || h.node_c_live) ? PAT_STEADY :
			((h.node_a_heard || h.node_c_heard) ? PAT_SLOW : PAT_OFF);
		chan_pat[3] = h.wifi_up ? PAT_STEADY : PAT_SLOW;
		chan_pat[4] = h.node_a_live ? PAT_STEADY : (h.node_a_heard ? PAT_DIM : PAT_OFF);
		chan_pat[5] = h.node_c_live ? PAT_STEADY : (h.node_c_seen ? PAT_DIM : PAT_OFF);
		chan_pat[6] = (h.node_c_live && h.pump_bit) ? PAT_FAST : PAT_OFF;
		chan_pat[7] = (h.heap_alert || h.storage_critical ||
			(h.node_c_seen && !h.battery_ok)) ? PAT_SLOW : PAT_OFF;
	endfunction

	// A tick queues one duty per channel and then steps the phase counters.
	function automatic void predict_item(input sled_in_t it);
		sled_out_t r;
		pat_t      p;
		if (it.kind == KIND_HEALTH) begin
			map_health(it);
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				p = (c < PAT_SLOTS) ? chan_pat[c] : PAT_OFF;
				r.channel  = CHF_W'(c);
				r.duty     = duty_for(p);
				r.full_on  = (r.duty == DUTY_MAX);
				r.full_off = (r.duty == '0);
				r.last     = (c == CHANNELS - 1);
				duty_queue.push_back(r);
			end
			slow_ph    = (slow_ph == SLOW_PERIOD - 1) ? '0 : slow_ph + 1'b1;
			fast_ph    = (fast_ph == FAST_PERIOD - 1) ? '0 : fast_ph + 1'b1;
			breathe_ph = (breathe_ph == BR_LAST) ? '0 : breathe_ph + 1'b1;
		end
	endfunction

	function automatic sled_in_t make_health(input logic fault, heap, stor, bat, cseen,
			wifi, a_alive, c_alive, a_heard, c_heard, pump);
		return '{kind: KIND_HEALTH, any_fault: fault, heap_alert: heap,
			storage_critical: stor, battery_ok: bat, node_c_seen: cseen,
			wifi_up: wifi, node_a_live: a_alive, node_c_live: c_alive,
			node_a_heard: a_heard, node_c_heard: c_heard, pump_bit: pump};
	endfunction

	// The flag bits of a tick are ignored by the engine, so they are random.
	function automatic sled_in_t make_tick();
		sled_in_t t;
		t = sled_in_t'($urandom);
		t.kind = KIND_TICK;
		return t;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	// Valid is only lowered for an idle cycle, so it never drops and rises
	// again within one time step between back-to-back transfers.
	task automatic send_item(input sled_in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		predict_item(it);
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (duty_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
			input logic [DUTY_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.wdata <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_FULL_LEVEL) begin
			full_lvl = value;
		end else if (idx == REG_DIM_LEVEL) begin
			dim_lvl = value;
		end
		@(posedge clk);
	endtask

	// Result sink: checks each transfer and draws the next ready.
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			if (duty_queue.size() == 0) begin
				note_failure($sformatf("unexpected result ch %0d duty %0d",
					result_ch.data.channel, result_ch.data.duty));
			end else begin
				want = duty_queue.pop_front();
				if (result_ch.data.channel !== want.channel ||
						result_ch.data.duty !== want.duty ||
						result_ch.data.full_on !== want.full_on ||
						result_ch.data.full_off !== want.full_off ||
						result_ch.data.last !== want.last) begin
					note_failure($sformatf(
						"expected ch %0d duty %0d on %b off %b last %b, got ch %0d duty %0d on %b off %b last %b",
						want.channel, want.duty, want.full_on, want.full_off, want.last,
						result_ch.data.channel, result_ch.data.duty, result_ch.data.full_on,
						result_ch.data.full_off, result_ch.data.last));
				end
			end
		end
		result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic test_reset_state();
		send_item(make_tick());
		send_item(make_tick());
		drain_results();
	endtask

	task automatic test_health_roles();
		// All flags clear, then all set.
		send_item(make_health(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_tick());
		send_item(make_health(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
		send_item(make_tick());
		// Nodes heard but not alive, battery fine.
		send_item(make_health(0, 0, 0, 1, 1, 1, 0, 0, 1, 1, 1));
		send_item(make_tick());
		// Node C seen with a flat battery; two updates in a row.
		send_item(make_health(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
		send_item(make_health(0, 0, 1, 1, 0, 0, 0, 0, 0, 1, 0));
		send_item(make_tick());
		// Node C alive with and without the pump running.
		send_item(make_health(0, 0, 0, 1, 0, 1, 0, 1, 0, 0, 0));
		send_item(make_tick());
		send_item(make_health(1, 0, 0, 1, 0, 1, 1, 1, 1, 0, 1));
		send_item(make_tick());
		drain_results();
	endtask

	task automatic test_level_extremes();
		write_reg(REG_FULL_LEVEL, '0);
		write_reg(REG_DIM_LEVEL, DUTY_MAX);
		write_reg(REG_SPARE_2, DUTY_W'($urandom));
		write_reg(REG_SPARE_3, DUTY_W'($urandom));
		send_item(make_health(1, 1, 0, 1, 1, 1, 1, 0, 1, 1, 0));
		send_item(make_tick());
		send_item(make_health(0, 0, 0, 1, 1, 0, 0, 0, 1, 0, 0));
		send_item(make_tick());
		drain_results();
		write_reg(REG_FULL_LEVEL, DUTY_MAX);
		write_reg(REG_DIM_LEVEL, '0);
		send_item(make_tick());
		send_item(make_health(1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 1));
		send_item(make_tick());
		drain_results();
	endtask

	task automatic test_random_traffic(input int count, input int send_pct,
			input int recv_pct);
		sled_in_t it;
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		write_reg(REG_FULL_LEVEL, DUTY_W'($urandom));
		write_reg(REG_DIM_LEVEL, DUTY_W'($urandom));
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 60) begin
				it = make_tick();
			end else begin
				it = sled_in_t'($urandom);
				it.kind = KIND_HEALTH;
			end
			send_item(it);
		end
		drain_results();
	endtask

	// The result channel is held off while ticks keep coming, so the engine
	// fills up and stalls its input; then the sender waits for every result.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		send_item(make_health(1, 0, 1, 0, 1, 0, 1, 1, 0, 1, 1));
		repeat (6) send_item(make_tick());
		drain_results();
		repeat (4) send_item(make_tick());
		drain_results();
	endtask

	initial begin
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.addr     = '0;
		cfg_ch.wdata    = '0;
		hold_off        = 1'b0;
		fail_count      = 0;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		for (int c = 0; c < PAT_SLOTS; c++) chan_pat[c] = PAT_OFF;
		slow_ph    = '0;
		fast_ph    = '0;
		breathe_ph = '0;
		full_lvl   = FULL_RESET;
		dim_lvl    = DIM_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_state();
		test_health_roles();
		test_level_extremes();
		test_random_traffic(120, 35, 49);
		test_random_traffic(120, 49, 35);
		test_random_traffic(110, 0, 0);
		test_output_backpressure();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && duty_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sled_pkg.sv
rtl/sled_if.sv
rtl/sled_pattern_store.sv
rtl/sled_phase_ctr.sv
rtl/sled_duty_unit.sv
rtl/status_led_pattern_engine.sv
sim/status_led_pattern_engine_test.sv
